// ===== hw/rtl/quaternion_to_euler_angles_assert.svh =====
// Assertion helpers for the quaternion to Euler angle RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define EUL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define EUL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/eul_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eul_pkg
// Widths, data types and the CORDIC angle table of the Euler angle pipeline.
// ----------------------------------------------------------------------------
package eul_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANG_TABLE_LEN     = 24;

    localparam int OPW    = 36;     // product sums, 2^28 per unit
    localparam int CW     = 38;     // CORDIC x / y datapath
    localparam int ZW     = 34;     // binary angle, 2^32 per turn
    localparam int SQ_W   = 57;     // square root remainder and root
    localparam int SQ_STEPS = 29;   // root bits 28 down to 0
    localparam int SP_W   = 29;     // pitch argument below saturation
    localparam int ROLL_W = 16;
    localparam int PITCH_W = 15;
    localparam int YAW_W  = 16;
    localparam int LIM_FULL = 23040;
    localparam int LIM_HALF = 11520;
    localparam int DEG128_PER_TURN = 46080;

    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);

    // one CORDIC cell's state
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zf;   // both operands zero
    } cord_t;

    // operands carried beside the square root chain
    typedef struct packed {
        logic signed [OPW-1:0]  sr;
        logic signed [OPW-1:0]  cr;
        logic signed [OPW-1:0]  sy;
        logic signed [OPW-1:0]  cy;
        logic signed [SP_W-1:0] sp;
        logic                   sat_pos;
        logic                   sat_neg;
    } side_t;

    // atan(2^-i) as a binary angle
    function automatic logic signed [ZW-1:0] eul_atan(input int idx);
        logic signed [ZW-1:0] a;
        case (idx)
            0:  a = ZW'(64'sd536870912);
            1:  a = ZW'(64'sd316933406);
            2:  a = ZW'(64'sd167458907);
            3:  a = ZW'(64'sd85004756);
            4:  a = ZW'(64'sd42667331);
            5:  a = ZW'(64'sd21354465);
            6:  a = ZW'(64'sd10679838);
            7:  a = ZW'(64'sd5340245);
            8:  a = ZW'(64'sd2670163);
            9:  a = ZW'(64'sd1335087);
            10: a = ZW'(64'sd667544);
            11: a = ZW'(64'sd333772);
            12: a = ZW'(64'sd166886);
            13: a = ZW'(64'sd83443);
            14: a = ZW'(64'sd41722);
            15: a = ZW'(64'sd20861);
            16: a = ZW'(64'sd10430);
            17: a = ZW'(64'sd5215);
            18: a = ZW'(64'sd2608);
            19: a = ZW'(64'sd1304);
            20: a = ZW'(64'sd652);
            21: a = ZW'(64'sd326);
            22: a = ZW'(64'sd163);
            23: a = ZW'(64'sd81);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/eul_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eul_sqrt_cell
// One digit of the restoring square root; carries the other operands along.
// ----------------------------------------------------------------------------
module eul_sqrt_cell
    import eul_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic            clk,
    input  logic            en,
    input  logic [SQ_W-1:0] n_in,
    input  logic [SQ_W-1:0] r_in,
    input  side_t           side_in,
    output logic [SQ_W-1:0] n_out,
    output logic [SQ_W-1:0] r_out,
    output side_t           side_out
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * STEP);

    logic [SQ_W-1:0] n_reg, n_next;
    logic [SQ_W-1:0] r_reg, r_next;
    side_t           side_reg;
    logic [SQ_W:0]   trial;

    always_comb
    begin
        trial = {1'b0, r_in} + {1'b0, BIT};
        if ({1'b0, n_in} >= trial)
        begin
            n_next = n_in - trial[SQ_W-1:0];
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            n_next = n_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            r_reg    <= r_next;
            side_reg <= side_in;
        end
    end

    assign n_out    = n_reg;
    assign r_out    = r_reg;
    assign side_out = side_reg;

endmodule

// ===== hw/rtl/eul_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eul_cordic_cell
// One vectoring iteration of the CORDIC arctangent.
// ----------------------------------------------------------------------------
module eul_cordic_cell
    import eul_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic  clk,
    input  logic  en,
    input  cord_t d_in,
    output cord_t d_out
);

    localparam logic signed [ZW-1:0] ANG = eul_atan(STEP);

    cord_t                d_reg, d_next;
    logic signed [CW-1:0] xv, yv, xs, ys;

    always_comb
    begin
        xv = d_in.x;
        yv = d_in.y;
        xs = xv >>> STEP;
        ys = yv >>> STEP;
        d_next.zf = d_in.zf;
        if (!yv[CW-1])
        begin
            d_next.x = xv + ys;
            d_next.y = yv - xs;
            d_next.z = d_in.z + ANG;
        end
        else
        begin
            d_next.x = xv - ys;
            d_next.y = yv + xs;
            d_next.z = d_in.z - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== hw/rtl/eul_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eul_cordic
// Four-quadrant arctangent: quadrant fold, a row of CORDIC cells, conversion
// of the binary angle to 1/128 degree with round half up and clamp.
// ----------------------------------------------------------------------------
module eul_cordic
    import eul_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int LIM    = LIM_FULL,
    parameter int OUT_W  = ROLL_W
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [CW-1:0]    y_in,
    input  logic signed [CW-1:0]    x_in,
    output logic signed [OUT_W-1:0] angle
);

    localparam int N = (STAGES > ANG_TABLE_LEN) ? ANG_TABLE_LEN : STAGES;
    localparam int PW = ZW + 18;
    localparam int DW = PW - 32;

    cord_t pre_reg, pre_next;
    cord_t chain [0:N];

    logic signed [PW-1:0]    prod_reg, prod_next;
    logic signed [OUT_W-1:0] angle_reg, angle_next;
    logic signed [PW-1:0]    rnd;
    logic signed [DW-1:0]    deg;

    always_comb
    begin
        pre_next.zf = (x_in == '0) && (y_in == '0);
        pre_next.x  = x_in;
        pre_next.y  = y_in;
        pre_next.z  = '0;
        if (x_in[CW-1])
        begin
            if (!y_in[CW-1])
            begin
                pre_next.x = y_in;
                pre_next.y = -x_in;
                pre_next.z = QUARTER_TURN;
            end
            else
            begin
                pre_next.x = -y_in;
                pre_next.y = x_in;
                pre_next.z = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg <= pre_next;
        end
    end

    assign chain[0] = pre_reg;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            eul_cordic_cell #(.STEP(gi)) u_cell
            (
                .clk   (clk),
                .en    (en),
                .d_in  (chain[gi]),
                .d_out (chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        if (chain[N].zf)
        begin
            prod_next = '0;
        end
        else
        begin
            prod_next = PW'(chain[N].z) * PW'(DEG128_PER_TURN);
        end
        rnd = prod_reg + (PW'(1) <<< 31);
        deg = DW'(rnd >>> 32);
        if (deg > DW'(LIM))
        begin
            angle_next = OUT_W'(LIM);
        end
        else if (deg < -DW'(LIM))
        begin
            angle_next = -OUT_W'(LIM);
        end
        else
        begin
            angle_next = OUT_W'(deg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion (Q1.14) to roll, pitch and yaw in 1/128 degree.
// ----------------------------------------------------------------------------
// Takes one quaternion per clock while s_axis_tready is high and returns one
// result transaction per quaternion, in order. A quaternion passes through
// product, sum, saturation and square stages, 29 square root cells, then a
// CORDIC row of CORDIC_STAGES cells plus three fold and conversion stages,
// and is then written into a two-entry output buffer from which it is
// offered. The pipeline only halts when that buffer is full; pitch saturates
// to +-90 degrees once |2(wy - zx)| reaches one.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles
    import eul_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // roll_angle, pitch_angle, yaw_angle, pad
);

`include "quaternion_to_euler_angles_assert.svh"

    localparam int N = (CORDIC_STAGES > ANG_TABLE_LEN) ? ANG_TABLE_LEN : CORDIC_STAGES;
    localparam int CLAT = N + 3;
    localparam int LAT = 4 + SQ_STEPS + CLAT;

    logic adv;
    logic [LAT-1:0] valid_reg;

    // stage 1: products
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg, wz_reg, xy_reg, zz_reg;

    // stage 2: sums
    logic signed [OPW-1:0] sr_reg, cr_reg, sp_reg, sy_reg, cy_reg;

    // stage 3: saturation and magnitude
    side_t           s3_reg, s3_next;
    logic [27:0]     mag_reg;
    logic signed [OPW-1:0] sp_abs;

    // stage 4: square
    side_t           s4_reg;
    logic [SQ_W-1:0] n4_reg;
    logic [55:0]     sq;

    logic [SQ_W-1:0] n_w [0:SQ_STEPS];
    logic [SQ_W-1:0] r_w [0:SQ_STEPS];
    side_t           side_w [0:SQ_STEPS];

    logic [1:0] sat_d_reg [0:CLAT-1];

    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch_cord, pitch;
    logic signed [YAW_W-1:0]   yaw;

    logic [47:0] buf_reg [0:1];
    logic        rd_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;
    logic signed [ROLL_W-1:0]  out_roll;
    logic signed [PITCH_W-1:0] out_pitch;

    assign adv = (cnt_reg != 2'd2);
    assign s_axis_tready = adv;

    assign qw = s_axis_tdata[15:0];
    assign qx = s_axis_tdata[31:16];
    assign qy = s_axis_tdata[47:32];
    assign qz = s_axis_tdata[63:48];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    always_comb
    begin
        sp_abs = sp_reg[OPW-1] ? -sp_reg : sp_reg;
        s3_next.sr = sr_reg;
        s3_next.cr = cr_reg;
        s3_next.sy = sy_reg;
        s3_next.cy = cy_reg;
        s3_next.sp = sp_reg[SP_W-1:0];
        s3_next.sat_pos = (sp_reg >= (OPW'(1) <<< 28));
        s3_next.sat_neg = (sp_reg <= -(OPW'(1) <<< 28));
        sq = {28'd0, mag_reg} * {28'd0, mag_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;

            sr_reg <= (OPW'(wx_reg) + OPW'(yz_reg)) <<< 1;
            cr_reg <= (OPW'(1) <<< 28) - ((OPW'(xx_reg) + OPW'(yy_reg)) <<< 1);
            sp_reg <= (OPW'(wy_reg) - OPW'(zx_reg)) <<< 1;
            sy_reg <= (OPW'(wz_reg) + OPW'(xy_reg)) <<< 1;
            cy_reg <= (OPW'(1) <<< 28) - ((OPW'(yy_reg) + OPW'(zz_reg)) <<< 1);

            s3_reg  <= s3_next;
            mag_reg <= sp_abs[27:0];

            s4_reg <= s3_reg;
            n4_reg <= (SQ_W'(1) << 56) - SQ_W'(sq);
        end
    end

    assign n_w[0]    = n4_reg;
    assign r_w[0]    = '0;
    assign side_w[0] = s4_reg;

    genvar gi;
    generate
        for (gi = 0; gi < SQ_STEPS; gi++)
        begin : g_sqrt
            eul_sqrt_cell #(.STEP(SQ_STEPS - 1 - gi)) u_cell
            (
                .clk      (clk),
                .en       (adv),
                .n_in     (n_w[gi]),
                .r_in     (r_w[gi]),
                .side_in  (side_w[gi]),
                .n_out    (n_w[gi+1]),
                .r_out    (r_w[gi+1]),
                .side_out (side_w[gi+1])
            );
        end
    endgenerate

    eul_cordic #(.STAGES(N), .LIM(LIM_FULL), .OUT_W(ROLL_W)) u_roll
    (
        .clk   (clk),
        .en    (adv),
        .y_in  (CW'(side_w[SQ_STEPS].sr)),
        .x_in  (CW'(side_w[SQ_STEPS].cr)),
        .angle (roll)
    );

    eul_cordic #(.STAGES(N), .LIM(LIM_HALF), .OUT_W(PITCH_W)) u_pitch
    (
        .clk   (clk),
        .en    (adv),
        .y_in  (CW'(side_w[SQ_STEPS].sp)),
        .x_in  (CW'(r_w[SQ_STEPS][SP_W-1:0])),
        .angle (pitch_cord)
    );

    eul_cordic #(.STAGES(N), .LIM(LIM_FULL), .OUT_W(YAW_W)) u_yaw
    (
        .clk   (clk),
        .en    (adv),
        .y_in  (CW'(side_w[SQ_STEPS].sy)),
        .x_in  (CW'(side_w[SQ_STEPS].cy)),
        .angle (yaw)
    );

    // saturation flags ride alongside the pitch CORDIC
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_d_reg[0] <= {side_w[SQ_STEPS].sat_pos, side_w[SQ_STEPS].sat_neg};
            for (int i = 1; i < CLAT; i++)
            begin
                sat_d_reg[i] <= sat_d_reg[i-1];
            end
        end
    end

    always_comb
    begin
        if (sat_d_reg[CLAT-1][1])
        begin
            pitch = PITCH_W'(LIM_HALF);
        end
        else if (sat_d_reg[CLAT-1][0])
        begin
            pitch = -PITCH_W'(LIM_HALF);
        end
        else
        begin
            pitch = pitch_cord;
        end
    end

    // two-entry output buffer
    assign push = adv && valid_reg[LAT-1];
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[rd_reg ^ cnt_reg[0]] <= {1'b0, yaw, pitch, roll};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = buf_reg[rd_reg];

    assign out_roll  = m_axis_tdata[15:0];
    assign out_pitch = m_axis_tdata[30:16];

    `EUL_ASSERT_ALWAYS(a_cnt_bound, cnt_reg != 2'd3, "output buffer count out of range")
    `EUL_ASSERT_ALWAYS(a_pitch_range, !m_axis_tvalid || (out_pitch <= 15'sd11520 && out_pitch >= -15'sd11520), "pitch out of range")
    `EUL_ASSERT_ALWAYS(a_roll_range, !m_axis_tvalid || (out_roll <= 16'sd23040 && out_roll >= -16'sd23040), "roll out of range")
    `EUL_ASSERT_NEXT(a_stall_hold, !adv, valid_reg == $past(valid_reg), "pipeline moved while stalled")
    `EUL_ASSERT_NEXT(a_push_count, push && !pop, cnt_reg == 2'($past(cnt_reg) + 2'd1), "buffer count missed a push")

endmodule

// ===== tb/sv/quaternion_to_euler_angles_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// Stream test of the quaternion to roll / pitch / yaw pipeline.
// ----------------------------------------------------------------------------
// A bit-exact predictor computes the angles of every accepted quaternion; a
// scoreboard compares each output transaction with the oldest prediction.
// Directed corner quaternions come first, then random unit and raw patterns
// under four phases: no idling, sender idling, receiver stalling, both.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb;
    import eul_pkg::*;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } angles_t;

    localparam longint ONE_Q28 = 64'sd1 << 28;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // quat_w, quat_x, quat_y, quat_z
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // roll_angle, pitch_angle, yaw_angle, pad

    int send_idle_pct;
    int recv_stall_pct;

    quaternion_to_euler_angles u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint atan_tab(int i);
        longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81};
        return t[i];
    endfunction

    function automatic longint root64(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vec_atan2(longint y, longint x);
        longint z;
        longint t;
        longint nx;
        longint ny;
        int n;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 64'sd1 << 30;
            end
            else
            begin
                x = -y; y = t; z = -(64'sd1 << 30);
            end
        end
        n = (CORDIC_STAGES_DEF > 24) ? 24 : CORDIC_STAGES_DEF;
        for (int i = 0; i < n; i++)
        begin
            if (y >= 0)
            begin
                nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += atan_tab(i);
            end
            else
            begin
                nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= atan_tab(i);
            end
            x = nx; y = ny;
        end
        return z;
    endfunction

    function automatic longint to_deg(longint z, longint lim);
        longint d;
        d = floor_shr(z * 46080 + (64'sd1 << 31), 32);
        if (d > lim) d = lim;
        if (d < -lim) d = -lim;
        return d;
    endfunction

    function automatic angles_t euler_of(logic [63:0] q);
        longint w, x, y, z, sr, cr, sp, sy, cy, c, p;
        angles_t a;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        sr = 2 * (w * x + y * z);
        cr = ONE_Q28 - 2 * (x * x + y * y);
        sp = 2 * (w * y - z * x);
        sy = 2 * (w * z + x * y);
        cy = ONE_Q28 - 2 * (y * y + z * z);
        if (sp >= ONE_Q28) p = LIM_HALF;
        else if (sp <= -ONE_Q28) p = -LIM_HALF;
        else
        begin
            c = root64((64'd1 << 56) - longint'(sp * sp));
            p = to_deg(vec_atan2(sp, c), LIM_HALF);
        end
        a.roll  = 16'(to_deg(vec_atan2(sr, cr), LIM_FULL));
        a.pitch = 15'(p);
        a.yaw   = 16'(to_deg(vec_atan2(sy, cy), LIM_FULL));
        return a;
    endfunction

    class angle_scoreboard;
        angles_t pending[$];
        int      errors;

        function void note_quat(logic [63:0] q);
            pending.push_back(euler_of(q));
        endfunction

        function void check_angles(logic [47:0] d);
            angles_t e;
            angles_t got;
            got.roll  = d[15:0];
            got.pitch = d[30:16];
            got.yaw   = d[46:31];
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", d);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/act)",
                        e.roll, got.roll, e.pitch, got.pitch, e.yaw, got.yaw);
            end
        endfunction
    endclass

    angle_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // output side: random stall, check every accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_angles(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // tvalid stays high after an accept and drops only when the sender idles
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x, w};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_quat({z, y, x, w});
    endtask

    // random unit-ish quaternion, or raw bit patterns now and then
    task automatic send_random();
        int k;
        real a, b, c, d, n;
        k = $urandom_range(9);
        if (k < 2)
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else if (k < 3)
        begin
            logic [15:0] v;
            v = ($urandom_range(1)) ? 16'sd11585 : -16'sd11585;
            // near gimbal lock: wy - zx close to one half
            send_quat(16'(v + $urandom_range(4) - 2), 16'($urandom_range(6) - 3),
                      16'(v + $urandom_range(4) - 2), 16'($urandom_range(6) - 3));
        end
        else
        begin
            a = $urandom_range(2000) - 1000.0;
            b = $urandom_range(2000) - 1000.0;
            c = $urandom_range(2000) - 1000.0;
            d = $urandom_range(2000) - 1000.0;
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) n = 1.0;
            send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                      16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
        end
    endtask

    initial
    begin
        int drain;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // identity, axis half turns, extremes, gimbal lock both ways
        send_quat(16'sd16384, 0, 0, 0);
        send_quat(-16'sd16384, 0, 0, 0);
        send_quat(0, 16'sd16384, 0, 0);
        send_quat(0, 0, 16'sd16384, 0);
        send_quat(0, 0, 0, 16'sd16384);
        send_quat(0, -16'sd16384, 0, 0);
        send_quat(0, 0, -16'sd16384, 0);
        send_quat(0, 0, 0, -16'sd16384);
        send_quat(16'sd11585, 0, 16'sd11585, 0);
        send_quat(16'sd11585, 0, -16'sd11585, 0);
        send_quat(16'sd11585, 16'sd11585, 16'sd11585, -16'sd11585);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        send_quat(0, 0, 0, 0);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_quat(16'sd14189, 16'sd8192, 0, 0);
        send_quat(0, 16'sd1, 0, 0);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 6 : 81) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 6 : 81) : 0;
            for (int i = 0; i < 100; i++)
                send_random();
        end
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 100)
        begin
            @(posedge clk);
            drain++;
        end
        if (sb.errors == 0)
            $display("quaternion_to_euler_angles verification clean");
        else
            $display("quaternion_to_euler_angles verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("quaternion_to_euler_angles verification failed");
        $finish;
    end

endmodule
